// ===== rtl/hpe_pkg.sv =====
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types, constants and the static Huffman code tables for the
// HPACK string encoder.
// ----------------------------------------------------------------------------
package hpe_pkg;

  localparam int CODE_W = 30;  // longest code
  localparam int LEN_W  = 5;   // code length field
  localparam int ACC_W  = 40;  // bit accumulator, left aligned
  localparam int CNT_W  = 6;   // bits in hand, up to 37

  // Input item
  typedef struct packed {
    logic [7:0] symbol;
    logic       string_last;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_t;

  // Queue entry from front to back: code left aligned in CODE_W bits
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } cmd_t;

  // Code values, right aligned
  localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
    30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
    30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
    30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
    30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
    30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
    30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
    30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
    30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
    30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
    30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
    30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
    30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
    30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
    30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
    30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
    30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
    30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
    30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
    30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
    30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
    30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
    30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
    30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
    30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
    30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
    30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
    30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
    30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
    30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  // Code lengths in bits
  localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

endpackage

// ===== rtl/hpe_front.sv =====
// ----------------------------------------------------------------------------
// hpe_front
// Accepts string bytes, looks up the static Huffman code and writes a
// left-aligned code with its length and string flag into the queue.
// ----------------------------------------------------------------------------
module hpe_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  hpe_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          q_push,
  output hpe_pkg::cmd_t q_wdata
);

  logic [hpe_pkg::CODE_W-1:0] code_raw;
  logic [hpe_pkg::LEN_W-1:0]  code_len;
  logic [hpe_pkg::LEN_W-1:0]  align_sh;

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Look up the code and move its first bit to the MSB
  always_comb begin
    code_raw = hpe_pkg::CODE_ROM[in_data.symbol];
    code_len = hpe_pkg::LEN_ROM[in_data.symbol];
    align_sh = hpe_pkg::LEN_W'(hpe_pkg::CODE_W) - code_len;
    q_wdata.code = code_raw << align_sh;
    q_wdata.len  = code_len;
    q_wdata.last = in_data.string_last;
  end

endmodule

// ===== rtl/hpe_queue.sv =====
// ----------------------------------------------------------------------------
// hpe_queue
// Small FIFO of looked-up codes between the front and the back end.
// ----------------------------------------------------------------------------
module hpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hpe_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output hpe_pkg::cmd_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hpe_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/hpe_back.sv =====
// ----------------------------------------------------------------------------
// hpe_back
// Bit accumulator: merges each code behind pending bits, then sends one byte
// per cycle, unless stalled, via an output register; pads a string's tail.
// ----------------------------------------------------------------------------
module hpe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  hpe_pkg::cmd_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output hpe_pkg::out_t out_data
);

  localparam int ACC_W = hpe_pkg::ACC_W;
  localparam int CNT_W = hpe_pkg::CNT_W;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  hpe_pkg::out_t    out_r, out_nxt;

  logic             idle;
  logic             slot_free;
  logic             emit;
  logic             have_byte;
  logic [CNT_W-1:0] rem;
  logic [7:0]       byte_val;
  logic             run_end;
  logic             str_end;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Nothing to send: fewer than 8 bits in hand and no pad owed
  always_comb begin
    have_byte = (total_r >= CNT_W'(8));
    idle      = !have_byte && !(last_r && (total_r != '0));
    slot_free = !out_valid_r || !out_stall;
    q_pop     = q_valid && idle;
    emit      = !idle && slot_free;
    rem       = have_byte ? (total_r - CNT_W'(8)) : '0;
    byte_val  = have_byte ? acc_r[ACC_W-1 -: 8]
                          : (acc_r[ACC_W-1 -: 8] | (8'hff >> total_r[2:0]));
    run_end   = (rem < CNT_W'(8)) && !(last_r && (rem != '0));
    str_end   = last_r && run_end;
  end

  // Load a code behind the pending bits, or shift out one byte
  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (q_pop) begin
      acc_nxt   = acc_r | ({q_rdata.code, (ACC_W - hpe_pkg::CODE_W)'(0)} >> total_r[2:0]);
      total_nxt = total_r + CNT_W'(q_rdata.len);
      last_nxt  = q_rdata.last;
    end
    if (emit) begin
      acc_nxt   = acc_r << 8;
      total_nxt = rem;
      if (str_end) begin
        acc_nxt  = '0;
        last_nxt = 1'b0;
      end
      out_valid_nxt       = 1'b1;
      out_nxt.out_byte    = byte_val;
      out_nxt.run_last    = run_end;
      out_nxt.string_end  = str_end;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      total_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      total_r     <= total_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`ifndef SYNTH
  // At most 7 pending bits plus a 30-bit code are ever in hand
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(37))
    else $error("accumulator holds more than 37 bits");

  // A string end byte always closes its item's run
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.string_end |-> out_r.run_last)
    else $error("string_end without run_last");

  // Every code is at least 5 bits, so a load leaves at least 5 bits in hand
  a_load_min: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> total_r >= CNT_W'(5))
    else $error("load left fewer than 5 bits");

  // Never load while a byte or pad is still owed
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !emit)
    else $error("load and emit in the same cycle");
`endif

endmodule

// ===== rtl/hpack_huffman_encoder.sv =====
// ----------------------------------------------------------------------------
// hpack_huffman_encoder
// HPACK static Huffman string encoder, one string byte in, encoded bytes out.
// ----------------------------------------------------------------------------
// The front end looks up each byte's code (5 to 30 bits) in a constant table
// and writes it into a QUEUE_DEPTH-entry queue in the cycle it is accepted.
// The back end takes a code from the queue into its bit accumulator only when
// no full byte or pad is owed, then sends one byte per cycle while out_stall
// is low, so it loads no new code until every full byte of the last is out.
// The byte-per-cycle output of the accumulator sets the throughput. An item
// that completes no byte produces no output; the last byte of a string is
// padded with ones.
module hpack_huffman_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hpe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hpe_pkg::out_t out_data
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  hpe_pkg::cmd_t q_wdata;
  hpe_pkg::cmd_t q_rdata;

  // Accept and look up
  hpe_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Decouple front and back
  hpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  // Pack bits and send bytes
  hpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
